>>> rtl/core/bptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure and temperature compensation package
// Shared widths, fixed-point scalings, status codes and configuration indexes.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // Wide multiplier geometry
  localparam int LIMB_W  = 32;
  localparam int MUL_AL  = 5;
  localparam int MUL_BL  = 2;
  localparam int MUL_A_W = MUL_AL * LIMB_W;
  localparam int MUL_B_W = MUL_BL * LIMB_W;
  localparam int MUL_R_W = MUL_A_W + LIMB_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Fixed-point scaling of the polynomial
  localparam int FRACTION_BITS = 48;
  localparam int DEN_BITS      = 3 * FRACTION_BITS + 37;
  localparam int T2_SHIFT      = FRACTION_BITS - 30;
  localparam int T_SHIFT       = FRACTION_BITS - 8;

  localparam int SH_P5  = DEN_BITS + 3;
  localparam int SH_P6  = DEN_BITS - 6 - FRACTION_BITS;
  localparam int SH_P7  = DEN_BITS - 8 - 2 * FRACTION_BITS;
  localparam int SH_P8  = DEN_BITS - 15 - 3 * FRACTION_BITS;
  localparam int SH_P1  = DEN_BITS - 20;
  localparam int SH_P2  = DEN_BITS - 29 - FRACTION_BITS;
  localparam int SH_P3  = DEN_BITS - 32 - 2 * FRACTION_BITS;
  localparam int SH_P4  = DEN_BITS - 37 - 3 * FRACTION_BITS;
  localparam int SH_P9  = DEN_BITS - 48;
  localparam int SH_P10 = DEN_BITS - 48 - FRACTION_BITS;
  localparam int SH_P11 = DEN_BITS - 65;

  localparam int Q_LSB = DEN_BITS - 6;
  localparam int Q_W   = MUL_P_W - Q_LSB;

  localparam logic signed [16:0] TRIM_OFFSET = 17'sd16384;
  localparam logic signed [63:0] TEMP_HALF   = 64'sd1 <<< (T_SHIFT - 1);
  localparam logic signed [23:0] TEMP_MAX    = 24'sd32767;
  localparam logic signed [23:0] TEMP_MIN    = -24'sd32768;

  localparam logic signed [MUL_P_W-1:0] PRESS_HALF = MUL_P_W'(1) <<< (Q_LSB - 1);
  localparam logic signed [MUL_P_W-1:0] PRESS_LO   = MUL_P_W'(1000) <<< DEN_BITS;
  localparam logic signed [MUL_P_W-1:0] PRESS_HI   = MUL_P_W'(110000) <<< DEN_BITS;
  localparam logic signed [Q_W-1:0]     PRESS_MAX  = Q_W'(8388607);

  // Status codes
  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMP_TRIM    = 2'd0;
  localparam logic [1:0] CFG_PRESS_TRIM_A = 2'd1;
  localparam logic [1:0] CFG_PRESS_TRIM_B = 2'd2;

endpackage

>>> rtl/core/bptc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined signed wide multiplier
// Sign-magnitude split, 32x32 partial products, two summing levels and a
// final sign restore: five register levels.
// ----------------------------------------------------------------------------
module bptc_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [bptc_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [bptc_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [bptc_pkg::MUL_P_W-1:0]  p_o
);
  import bptc_pkg::*;

  logic [MUL_A_W-1:0]  a_mag_q;
  logic [MUL_B_W-1:0]  b_mag_q;
  logic [3:0]          neg_q;
  logic [2*LIMB_W-1:0] pp_q [MUL_AL][MUL_BL];
  logic [MUL_R_W-1:0]  row_q [MUL_BL];
  logic [MUL_R_W-1:0]  row_d [MUL_BL];
  logic [MUL_P_W-1:0]  sum_q;
  logic [MUL_P_W-1:0]  p_q;

  always_comb begin
    for (int j = 0; j < MUL_BL; j++) begin
      logic [MUL_R_W-1:0] ev;
      logic [MUL_R_W-1:0] od;
      ev = '0;
      od = '0;
      for (int i = 0; i < MUL_AL; i++) begin
        if (i % 2 == 0) begin
          ev = ev | (MUL_R_W'(pp_q[i][j]) << (LIMB_W * i));
        end else begin
          od = od | (MUL_R_W'(pp_q[i][j]) << (LIMB_W * i));
        end
      end
      row_d[j] = ev + od;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q  <= a_i[MUL_A_W-1] ? (~a_i + MUL_A_W'(1)) : a_i;
      b_mag_q  <= b_i[MUL_B_W-1] ? (~b_i + MUL_B_W'(1)) : b_i;
      neg_q[0] <= a_i[MUL_A_W-1] ^ b_i[MUL_B_W-1];
      for (int i = 0; i < MUL_AL; i++) begin
        for (int j = 0; j < MUL_BL; j++) begin
          pp_q[i][j] <= a_mag_q[LIMB_W*i +: LIMB_W] * b_mag_q[LIMB_W*j +: LIMB_W];
        end
      end
      neg_q[1] <= neg_q[0];
      for (int j = 0; j < MUL_BL; j++) begin
        row_q[j] <= row_d[j];
      end
      neg_q[2] <= neg_q[1];
      sum_q    <= MUL_P_W'(row_q[0]) + (MUL_P_W'(row_q[1]) << LIMB_W);
      neg_q[3] <= neg_q[2];
      p_q      <= neg_q[3] ? (~sum_q + MUL_P_W'(1)) : sum_q;
    end
  end

  assign p_o = $signed(p_q);

endmodule

>>> rtl/core/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure and temperature compensation
// Linearises a raw temperature and evaluates the cubic pressure polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   Load the three trim registers through the write port while the block is
//   empty. Each input beat carries one raw pressure and one raw temperature;
//   each output beat carries temperature (1/256 C), pressure (1/64 Pa) and a
//   status code.
//   One beat is taken every cycle while the output beat is not held. The
//   path is 24 register stages: four set up the trim products, then three
//   wide multipliers, each followed by one add stage, evaluate the
//   polynomial in Horner form, then one rounding stage and one saturation
//   stage.
//   All stages advance together; when the output beat is held by the
//   receiver, the whole pipeline holds and in_ready_o drops in the same
//   cycle. Nothing is dropped or repeated.
//   Reset empties the pipeline and clears the trim registers to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [23:0]        raw_pressure_i,
  input  logic [23:0]        raw_temperature_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] temperature_o,
  output logic [22:0]        pressure_o,
  output logic [1:0]         status_o
);
  import bptc_pkg::*;

  localparam int NSTG     = 24;
  localparam int D_W      = 25;
  localparam int DT2_W    = 42;
  localparam int DD_W     = 50;
  localparam int DDT3_W   = 58;
  localparam int RPSQ_W   = 48;
  localparam int RPCU_W   = 72;
  localparam int P1RP_W   = 42;
  localparam int P3RP_W   = 33;
  localparam int P9RP_W   = 65;
  localparam int P10RP_W  = 57;
  localparam int P11RP_W  = 81;
  localparam int C3_W     = 34;
  localparam int C2_W     = 88;
  localparam int C1_W     = 148;
  localparam int C0_W     = 206;
  localparam int NR_DLY   = 22;
  localparam int TQ_DLY   = 18;
  localparam int C2_DLY   = 5;
  localparam int C1_DLY   = 11;
  localparam int C0_DLY   = 16;
  localparam int E_DLY    = 12;
  localparam int E_TAP2   = 5;

  logic adv;

  // Trim registers and fields
  logic [39:0] temp_trim_q;
  logic [63:0] press_trim_a_q;
  logic [63:0] press_trim_b_q;

  logic signed [16:0] t2_s, p1_s, p2_s, p5_s, p6_s;
  logic signed [7:0]  t3_s, p3_s, p4_s, p7_s, p8_s, p10_s, p11_s;
  logic signed [15:0] p9_s;

  assign t2_s  = $signed({1'b0, temp_trim_q[31:16]});
  assign t3_s  = $signed(temp_trim_q[39:32]);
  assign p1_s  = 17'($signed(press_trim_a_q[15:0])) - TRIM_OFFSET;
  assign p2_s  = 17'($signed(press_trim_a_q[31:16])) - TRIM_OFFSET;
  assign p3_s  = $signed(press_trim_a_q[39:32]);
  assign p4_s  = $signed(press_trim_a_q[47:40]);
  assign p5_s  = $signed({1'b0, press_trim_a_q[63:48]});
  assign p6_s  = $signed({1'b0, press_trim_b_q[15:0]});
  assign p7_s  = $signed(press_trim_b_q[23:16]);
  assign p8_s  = $signed(press_trim_b_q[31:24]);
  assign p9_s  = $signed(press_trim_b_q[47:32]);
  assign p10_s = $signed(press_trim_b_q[55:48]);
  assign p11_s = $signed(press_trim_b_q[63:56]);

  // Pipeline registers
  logic [NSTG-1:0]            vld_q;
  logic [23:0]                rp_s1_q;
  logic signed [D_W-1:0]      d_s1_q;
  logic                       nr_s1_q;
  logic [23:0]                rp_s2_q;
  logic signed [DT2_W-1:0]    dt2_s2_q;
  logic signed [DD_W-1:0]     dd_s2_q;
  logic [RPSQ_W-1:0]          rpsq_s2_q;
  logic signed [DT2_W-1:0]    dt2_s3_q;
  logic signed [DDT3_W-1:0]   ddt3_s3_q;
  logic [RPCU_W-1:0]          rpcu_s3_q;
  logic signed [P1RP_W-1:0]   p1rp_s3_q, p2rp_s3_q, p1rp_s4_q;
  logic signed [P3RP_W-1:0]   p3rp_s3_q, p4rp_s3_q;
  logic signed [P9RP_W-1:0]   p9rp_s3_q, p9rp_s4_q;
  logic signed [P10RP_W-1:0]  p10rp_s3_q;
  logic signed [P11RP_W-1:0]  p11rp_s4_q;
  logic signed [MUL_B_W-1:0]  e_s4_q;
  logic signed [C3_W-1:0]     c3_s4_q;
  logic signed [C2_W-1:0]     c2_s4_q;
  logic signed [C1_W-1:0]     c1_s4_q;
  logic signed [C0_W-1:0]     c0_s5_q;
  logic signed [15:0]         tq_s5_q;
  logic signed [MUL_A_W-1:0]  x2_q, x1_q;
  logic signed [MUL_P_W-1:0]  acc_q, rnd_q;
  logic                       above_lo_q, below_hi_q;
  logic signed [15:0]         temperature_q;
  logic [22:0]                pressure_q;
  logic [1:0]                 status_q;

  logic                       nr_dly_q [NR_DLY];
  logic signed [15:0]         tq_dly_q [TQ_DLY];
  logic signed [C2_W-1:0]     c2_dly_q [C2_DLY];
  logic signed [C1_W-1:0]     c1_dly_q [C1_DLY];
  logic signed [C0_W-1:0]     c0_dly_q [C0_DLY];
  logic signed [MUL_B_W-1:0]  e_dly_q  [E_DLY];

  logic signed [MUL_P_W-1:0]  prod1, prod2, prod3;

  // Combinational stage logic
  logic signed [D_W:0]        rp_sgn;
  logic signed [RPSQ_W:0]     rpsq_sgn;
  logic signed [RPCU_W:0]     rpcu_sgn;
  logic signed [D_W-1:0]      d_d;
  logic signed [63:0]         t_rnd_d;
  logic signed [23:0]         t_full_d;
  logic signed [15:0]         tq_d;
  logic signed [Q_W-1:0]      q_d;
  logic [22:0]                psat_d;

  assign rp_sgn   = $signed({1'b0, rp_s2_q});
  assign rpsq_sgn = $signed({1'b0, rpsq_s2_q});
  assign rpcu_sgn = $signed({1'b0, rpcu_s3_q});
  assign d_d      = $signed({1'b0, raw_temperature_i}) -
                    $signed({1'b0, temp_trim_q[15:0], 8'd0});

  always_comb begin
    t_rnd_d  = e_s4_q + TEMP_HALF;
    t_full_d = $signed(t_rnd_d[63:T_SHIFT]);
    if (t_full_d > TEMP_MAX) begin
      tq_d = 16'(TEMP_MAX);
    end else if (t_full_d < TEMP_MIN) begin
      tq_d = 16'(TEMP_MIN);
    end else begin
      tq_d = 16'(t_full_d);
    end
  end

  always_comb begin
    q_d = $signed(rnd_q[MUL_P_W-1:Q_LSB]);
    if (q_d[Q_W-1]) begin
      psat_d = '0;
    end else if (q_d > PRESS_MAX) begin
      psat_d = 23'(PRESS_MAX);
    end else begin
      psat_d = q_d[22:0];
    end
  end

  assign adv        = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = adv;

  // Control and trim registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q          <= '0;
      temp_trim_q    <= '0;
      press_trim_a_q <= '0;
      press_trim_b_q <= '0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NSTG-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TEMP_TRIM:    temp_trim_q    <= cfg_wdata_i[39:0];
          CFG_PRESS_TRIM_A: press_trim_a_q <= cfg_wdata_i;
          CFG_PRESS_TRIM_B: press_trim_b_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rp_s1_q    <= raw_pressure_i;
      d_s1_q     <= d_d;
      nr_s1_q    <= (raw_pressure_i == '0) || (raw_temperature_i == '0);

      rp_s2_q    <= rp_s1_q;
      dt2_s2_q   <= d_s1_q * t2_s;
      dd_s2_q    <= d_s1_q * d_s1_q;
      rpsq_s2_q  <= rp_s1_q * rp_s1_q;

      dt2_s3_q   <= dt2_s2_q;
      ddt3_s3_q  <= dd_s2_q * t3_s;
      rpcu_s3_q  <= rpsq_s2_q * rp_s2_q;
      p1rp_s3_q  <= p1_s * rp_sgn;
      p2rp_s3_q  <= p2_s * rp_sgn;
      p3rp_s3_q  <= p3_s * rp_sgn;
      p4rp_s3_q  <= p4_s * rp_sgn;
      p9rp_s3_q  <= p9_s * rpsq_sgn;
      p10rp_s3_q <= p10_s * rpsq_sgn;

      e_s4_q     <= (MUL_B_W'(dt2_s3_q) <<< T2_SHIFT) + MUL_B_W'(ddt3_s3_q);
      c3_s4_q    <= (C3_W'(p8_s) <<< SH_P8) + (C3_W'(p4rp_s3_q) <<< SH_P4);
      c2_s4_q    <= (C2_W'(p7_s) <<< SH_P7) + (C2_W'(p3rp_s3_q) <<< SH_P3);
      c1_s4_q    <= (C1_W'(p6_s) <<< SH_P6) + (C1_W'(p2rp_s3_q) <<< SH_P2) +
                    (C1_W'(p10rp_s3_q) <<< SH_P10);
      p11rp_s4_q <= p11_s * rpcu_sgn;
      p1rp_s4_q  <= p1rp_s3_q;
      p9rp_s4_q  <= p9rp_s3_q;

      c0_s5_q    <= (C0_W'(p5_s) <<< SH_P5) + (C0_W'(p1rp_s4_q) <<< SH_P1) +
                    (C0_W'(p9rp_s4_q) <<< SH_P9) + (C0_W'(p11rp_s4_q) <<< SH_P11);
      tq_s5_q    <= tq_d;

      x2_q       <= MUL_A_W'(MUL_P_W'(c2_dly_q[C2_DLY-1]) + prod1);
      x1_q       <= MUL_A_W'(MUL_P_W'(c1_dly_q[C1_DLY-1]) + prod2);
      acc_q      <= MUL_P_W'(c0_dly_q[C0_DLY-1]) + prod3;

      rnd_q      <= acc_q + PRESS_HALF;
      above_lo_q <= acc_q > PRESS_LO;
      below_hi_q <= acc_q < PRESS_HI;

      if (nr_dly_q[NR_DLY-1]) begin
        temperature_q <= '0;
        pressure_q    <= '0;
        status_q      <= ST_NOT_READY;
      end else begin
        temperature_q <= tq_dly_q[TQ_DLY-1];
        pressure_q    <= psat_d;
        status_q      <= (above_lo_q && below_hi_q) ? ST_GOOD : ST_RANGE;
      end

      nr_dly_q[0] <= nr_s1_q;
      tq_dly_q[0] <= tq_s5_q;
      c2_dly_q[0] <= c2_s4_q;
      c1_dly_q[0] <= c1_s4_q;
      c0_dly_q[0] <= c0_s5_q;
      e_dly_q[0]  <= e_s4_q;
      for (int i = 1; i < NR_DLY; i++) nr_dly_q[i] <= nr_dly_q[i-1];
      for (int i = 1; i < TQ_DLY; i++) tq_dly_q[i] <= tq_dly_q[i-1];
      for (int i = 1; i < C2_DLY; i++) c2_dly_q[i] <= c2_dly_q[i-1];
      for (int i = 1; i < C1_DLY; i++) c1_dly_q[i] <= c1_dly_q[i-1];
      for (int i = 1; i < C0_DLY; i++) c0_dly_q[i] <= c0_dly_q[i-1];
      for (int i = 1; i < E_DLY; i++)  e_dly_q[i]  <= e_dly_q[i-1];
    end
  end

  // Horner evaluation in the linearised temperature
  bptc_mul u_mul_c3 (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (MUL_A_W'(c3_s4_q)),
    .b_i   (e_s4_q),
    .p_o   (prod1)
  );

  bptc_mul u_mul_x2 (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (x2_q),
    .b_i   (e_dly_q[E_TAP2]),
    .p_o   (prod2)
  );

  bptc_mul u_mul_x1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (x1_q),
    .b_i   (e_dly_q[E_DLY-1]),
    .p_o   (prod3)
  );

  assign out_valid_o   = vld_q[NSTG-1];
  assign temperature_o = temperature_q;
  assign pressure_o    = pressure_q;
  assign status_o      = status_q;

  // Assertions
  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOT_READY |-> temperature_o == '0 && pressure_o == '0)
    else $error("not-ready beat carries non-zero results");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_GOOD || status_o == ST_NOT_READY ||
                    status_o == ST_RANGE)
    else $error("status code outside defined set");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output held");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat lost at entry");

endmodule
